// File: rtl/rcs_pkg.sv
// shared types and constants for the column ray setup pipeline
`timescale 1ns / 1ps
package rcs_pkg;
	localparam int SCREEN_WIDTH_DEF = 640;
	localparam int COL_W = 10;
	localparam int POS_W = 24;
	localparam int VEC_W = 18;
	localparam int DIR_W = 19;
	localparam int DIST_W = 24;
	localparam int NUM_W = 33;
	localparam int GAP_W = 17;
	localparam int CAM_W = 28;
	localparam int CAM_LAT = 3;
	localparam int DIR_LAT = 2;
	localparam int DIV_LAT = DIST_W + 1;
	localparam logic [DIST_W-1:0] DIST_MAX = '1;

	localparam logic [2:0] REG_POS_X = 3'd0;
	localparam logic [2:0] REG_POS_Y = 3'd1;
	localparam logic [2:0] REG_FACING_X = 3'd2;
	localparam logic [2:0] REG_FACING_Y = 3'd3;
	localparam logic [2:0] REG_PLANE_X = 3'd4;
	localparam logic [2:0] REG_PLANE_Y = 3'd5;

	typedef struct packed {
		logic signed [DIR_W-1:0] dir;
		logic [DIR_W-1:0] mag;
		logic [GAP_W-1:0] gap;
		logic step_pos;
	} axis_t;

	typedef struct packed {
		logic [COL_W-1:0] column;
		logic signed [DIR_W-1:0] dir_x;
		logic signed [DIR_W-1:0] dir_y;
		logic step_x;
		logic step_y;
	} side_t;
endpackage

// File: rtl/rcs_camera.sv
// column to camera space, floor(2*column*65536/width) - 65536, over three stages
`timescale 1ns / 1ps
module rcs_camera #(
	parameter int SCREEN_WIDTH = rcs_pkg::SCREEN_WIDTH_DEF
) (
	input  logic clk,
	input  logic en,
	input  logic [rcs_pkg::COL_W-1:0] column,
	output logic [rcs_pkg::COL_W-1:0] column_out,
	output logic signed [rcs_pkg::CAM_W-1:0] cam
);
	localparam int N_W = rcs_pkg::COL_W + 17;
	localparam int SH = N_W + 1;
	localparam logic [SH-1:0] RECIP = SH'((64'd1 << SH) / SCREEN_WIDTH);
	localparam logic [N_W-1:0] WIDTH_N = N_W'(SCREEN_WIDTH);
	localparam int Q_W = N_W - 1;

	logic [N_W-1:0] n_in;
	logic [N_W+SH-1:0] prod_s1;
	logic [N_W-1:0] n_s1, n_s2;
	logic [rcs_pkg::COL_W-1:0] col_s1, col_s2, col_s3;
	logic [Q_W-1:0] qe_s2;
	logic [Q_W+13:0] qw_s2;
	logic [Q_W-1:0] qe_s1;
	logic [N_W-1:0] rem_s2;
	logic [Q_W-1:0] q_s2;
	logic signed [rcs_pkg::CAM_W-1:0] cam_s3;

	assign n_in = {column, 17'd0};
	assign qe_s1 = Q_W'(prod_s1 >> SH);
	assign rem_s2 = n_s2 - qw_s2[N_W-1:0];
	assign q_s2 = qe_s2 + Q_W'(rem_s2 >= WIDTH_N);

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= (N_W+SH)'(n_in) * (N_W+SH)'(RECIP);
			n_s1 <= n_in;
			col_s1 <= column;
			qe_s2 <= qe_s1;
			qw_s2 <= (Q_W+14)'(qe_s1) * (Q_W+14)'(SCREEN_WIDTH);
			n_s2 <= n_s1;
			col_s2 <= col_s1;
			cam_s3 <= $signed(rcs_pkg::CAM_W'(q_s2)) - rcs_pkg::CAM_W'(65536);
			col_s3 <= col_s2;
		end
	end

	assign cam = cam_s3;
	assign column_out = col_s3;
endmodule

// File: rtl/rcs_dir.sv
// ray direction per axis, saturation, step sign and edge distance over two stages
`timescale 1ns / 1ps
module rcs_dir (
	input  logic clk,
	input  logic en,
	input  logic [rcs_pkg::COL_W-1:0] column,
	input  logic signed [rcs_pkg::CAM_W-1:0] cam,
	input  logic signed [rcs_pkg::VEC_W-1:0] facing_x,
	input  logic signed [rcs_pkg::VEC_W-1:0] facing_y,
	input  logic signed [rcs_pkg::VEC_W-1:0] plane_x,
	input  logic signed [rcs_pkg::VEC_W-1:0] plane_y,
	input  logic [15:0] frac_x,
	input  logic [15:0] frac_y,
	output logic [rcs_pkg::COL_W-1:0] column_out,
	output rcs_pkg::axis_t axis_x,
	output rcs_pkg::axis_t axis_y
);
	localparam int P_W = rcs_pkg::VEC_W + rcs_pkg::CAM_W;
	localparam int S_W = P_W - 15;

	logic signed [P_W-1:0] prod_x_s4, prod_y_s4;
	logic [rcs_pkg::COL_W-1:0] col_s4, col_s5;
	rcs_pkg::axis_t ax_s5, ay_s5, ax_d, ay_d;

	function automatic rcs_pkg::axis_t make_axis(input logic signed [P_W-1:0] prod,
			input logic signed [rcs_pkg::VEC_W-1:0] facing, input logic [15:0] frac);
		logic signed [S_W-1:0] sum;
		logic signed [rcs_pkg::DIR_W-1:0] d;
		rcs_pkg::axis_t a;
		sum = S_W'(prod >>> 16) + S_W'(facing);
		if (sum > S_W'(262143)) d = 19'sd262143;
		else if (sum < -S_W'(262144)) d = -19'sd262144;
		else d = rcs_pkg::DIR_W'(sum);
		a.dir = d;
		a.mag = d[rcs_pkg::DIR_W-1] ? rcs_pkg::DIR_W'(-d) : rcs_pkg::DIR_W'(d);
		a.gap = d[rcs_pkg::DIR_W-1] ? {1'b0, frac} : 17'h10000 - {1'b0, frac};
		a.step_pos = !d[rcs_pkg::DIR_W-1] && (d != '0);
		return a;
	endfunction

	assign ax_d = make_axis(prod_x_s4, facing_x, frac_x);
	assign ay_d = make_axis(prod_y_s4, facing_y, frac_y);

	always_ff @(posedge clk) begin
		if (en) begin
			prod_x_s4 <= P_W'(plane_x) * P_W'(cam);
			prod_y_s4 <= P_W'(plane_y) * P_W'(cam);
			col_s4 <= column;
			ax_s5 <= ax_d;
			ay_s5 <= ay_d;
			col_s5 <= col_s4;
		end
	end

	assign column_out = col_s5;
	assign axis_x = ax_s5;
	assign axis_y = ay_s5;
endmodule

// File: rtl/rcs_div.sv
// pipelined restoring divider, one quotient bit per stage, saturating
`timescale 1ns / 1ps
module rcs_div (
	input  logic clk,
	input  logic en,
	input  logic [rcs_pkg::NUM_W-1:0] num,
	input  logic [rcs_pkg::DIR_W-1:0] mag,
	output logic [rcs_pkg::DIST_W-1:0] quo
);
	localparam int STEPS = rcs_pkg::DIST_W;
	localparam int CMP_W = rcs_pkg::DIR_W + STEPS;

	logic [rcs_pkg::NUM_W-1:0] rem_s [0:STEPS];
	logic [STEPS-1:0] quo_s [0:STEPS];
	logic [rcs_pkg::DIR_W-1:0] mag_s [0:STEPS];
	logic sat_s [0:STEPS];

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= num;
			quo_s[0] <= '0;
			mag_s[0] <= mag;
			sat_s[0] <= (mag == '0) || (CMP_W'(num) >= (CMP_W'(mag) << STEPS));
		end
	end

	for (genvar i = 0; i < STEPS; i++) begin : g_step
		localparam int K = STEPS - 1 - i;
		logic [CMP_W-1:0] sub;
		logic take;
		assign sub = CMP_W'(mag_s[i]) << K;
		assign take = CMP_W'(rem_s[i]) >= sub;
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1] <= take ? rem_s[i] - rcs_pkg::NUM_W'(sub) : rem_s[i];
				quo_s[i+1] <= quo_s[i] | (STEPS'(take) << K);
				mag_s[i+1] <= mag_s[i];
				sat_s[i+1] <= sat_s[i];
			end
		end
	end

	assign quo = sat_s[STEPS] ? rcs_pkg::DIST_MAX : quo_s[STEPS];
endmodule

// File: rtl/raycast_column_ray_setup.sv
// top level of the column ray setup pipeline
`timescale 1ns / 1ps
// Takes one column per clock, unless the output stalls, and returns its ray setup
// after three stages of camera mapping, two of direction forming and a
// 25-stage divider (one saturation check plus one quotient bit per stage) that
// produces the delta and side distances. The whole pipeline holds on a stall
// of the output, so one transfer per clock holds only while it is not stalled.
module raycast_column_ray_setup #(
	parameter int SCREEN_WIDTH = rcs_pkg::SCREEN_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [rcs_pkg::POS_W-1:0] cfg_data,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [15:0] s_tdata, // column
	output logic m_tvalid,
	input  logic m_tready,
	// column_out, ray_dir_x, ray_dir_y, start_cell_x, start_cell_y, step_x_positive,
	// step_y_positive, delta_dist_x, delta_dist_y, side_dist_x, side_dist_y
	output logic [167:0] m_tdata
);
	localparam int LAT = rcs_pkg::CAM_LAT + rcs_pkg::DIR_LAT + rcs_pkg::DIV_LAT;
	localparam logic [rcs_pkg::NUM_W-1:0] ONE_32 = rcs_pkg::NUM_W'(64'h1_0000_0000);

	logic [rcs_pkg::POS_W-1:0] pos_x_q, pos_y_q;
	logic signed [rcs_pkg::VEC_W-1:0] facing_x_q, facing_y_q, plane_x_q, plane_y_q;
	logic [LAT-1:0] valid_q;
	logic en;
	logic [rcs_pkg::COL_W-1:0] col_cam, col_dir;
	logic signed [rcs_pkg::CAM_W-1:0] cam;
	rcs_pkg::axis_t axis_x, axis_y;
	rcs_pkg::side_t side_s [0:rcs_pkg::DIV_LAT-1];
	rcs_pkg::side_t side_out;
	logic [rcs_pkg::DIST_W-1:0] delta_x, delta_y, sdist_x, sdist_y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q <= '0;
			pos_y_q <= '0;
			facing_x_q <= 18'sd65536;
			facing_y_q <= '0;
			plane_x_q <= '0;
			plane_y_q <= 18'sd43254;
		end else if (cfg_we) begin
			case (cfg_index)
				rcs_pkg::REG_POS_X: pos_x_q <= cfg_data;
				rcs_pkg::REG_POS_Y: pos_y_q <= cfg_data;
				rcs_pkg::REG_FACING_X: facing_x_q <= cfg_data[rcs_pkg::VEC_W-1:0];
				rcs_pkg::REG_FACING_Y: facing_y_q <= cfg_data[rcs_pkg::VEC_W-1:0];
				rcs_pkg::REG_PLANE_X: plane_x_q <= cfg_data[rcs_pkg::VEC_W-1:0];
				rcs_pkg::REG_PLANE_Y: plane_y_q <= cfg_data[rcs_pkg::VEC_W-1:0];
				default: ;
			endcase
		end
	end

	assign en = !valid_q[LAT-1] || m_tready;
	assign s_tready = en;
	assign m_tvalid = valid_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_q <= '0;
		else if (en) valid_q <= {valid_q[LAT-2:0], s_tvalid};
	end

	rcs_camera #(.SCREEN_WIDTH(SCREEN_WIDTH)) u_camera (
		.clk(clk), .en(en), .column(s_tdata[rcs_pkg::COL_W-1:0]),
		.column_out(col_cam), .cam(cam)
	);

	rcs_dir u_dir (
		.clk(clk), .en(en), .column(col_cam), .cam(cam),
		.facing_x(facing_x_q), .facing_y(facing_y_q),
		.plane_x(plane_x_q), .plane_y(plane_y_q),
		.frac_x(pos_x_q[15:0]), .frac_y(pos_y_q[15:0]),
		.column_out(col_dir), .axis_x(axis_x), .axis_y(axis_y)
	);

	rcs_div u_delta_x (.clk(clk), .en(en), .num(ONE_32), .mag(axis_x.mag), .quo(delta_x));
	rcs_div u_delta_y (.clk(clk), .en(en), .num(ONE_32), .mag(axis_y.mag), .quo(delta_y));
	rcs_div u_side_x (.clk(clk), .en(en), .num({axis_x.gap, 16'd0}), .mag(axis_x.mag),
		.quo(sdist_x));
	rcs_div u_side_y (.clk(clk), .en(en), .num({axis_y.gap, 16'd0}), .mag(axis_y.mag),
		.quo(sdist_y));

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0] <= '{column: col_dir, dir_x: axis_x.dir, dir_y: axis_y.dir,
				step_x: axis_x.step_pos, step_y: axis_y.step_pos};
			for (int i = 1; i < rcs_pkg::DIV_LAT; i++) side_s[i] <= side_s[i-1];
		end
	end

	assign side_out = side_s[rcs_pkg::DIV_LAT-1];
	assign m_tdata = {6'd0, sdist_y, sdist_x, delta_y, delta_x, side_out.step_y,
		side_out.step_x, pos_y_q[23:16], pos_x_q[23:16], side_out.dir_y, side_out.dir_x,
		side_out.column};

`ifndef ASSERT_OFF
	a_zero_x: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[28:10] == '0 |-> m_tdata[89:66] == rcs_pkg::DIST_MAX
		&& m_tdata[137:114] == rcs_pkg::DIST_MAX && !m_tdata[64])
		else $error("zero x direction not saturated");
	a_zero_y: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[47:29] == '0 |-> m_tdata[113:90] == rcs_pkg::DIST_MAX
		&& m_tdata[161:138] == rcs_pkg::DIST_MAX && !m_tdata[65])
		else $error("zero y direction not saturated");
	a_step_x: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[64] |-> !m_tdata[28])
		else $error("x step sign disagrees with direction");
	a_step_y: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[65] |-> !m_tdata[47])
		else $error("y step sign disagrees with direction");
`endif
endmodule
